// ===== sv/rwcd_pkg.sv =====
`timescale 1ns / 1ps

package rwcd_pkg;

  localparam int TXN_W  = 16;
  localparam int ATTR_W = 8;

  // Item opcodes
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic [ATTR_W-1:0] attribute;
    logic              is_write;
    logic [TXN_W-1:0]  txn_id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/rwcd_ram.sv =====
`timescale 1ns / 1ps

module rwcd_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/rw_conflict_detector.sv =====
`timescale 1ns / 1ps
// A clear beat goes from acceptance to S_DONE and then into the output register; an
// append beat first reads log entries in S_SCAN (newest first, one per cycle through
// the log RAM read port, at most LOG_DEPTH) before S_DONE.
// One item at a time: in_stall is high until the result moves from S_DONE into the
// output register, a move that waits while out_stall holds the previous result.
// Reset (rst_n low, synchronous): log empty, no result pending; RAM contents kept.
module rw_conflict_detector
  import rwcd_pkg::*;
#(
  parameter int LOG_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [TXN_W-1:0]  in_txn_id,
  input  logic              in_is_write,
  input  logic [ATTR_W-1:0] in_attribute,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_conflict_found,
  output logic [TXN_W-1:0]  out_conflict_txn,
  output logic              out_overflow
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [TXN_W-1:0]  txn_r, txn_nxt;
  logic              wr_r, wr_nxt;
  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic              found_r, found_nxt;
  logic [TXN_W-1:0]  ctxn_r, ctxn_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [TXN_W-1:0]  out_txn_r, out_txn_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic          in_fire;
  logic          out_free;
  logic          not_full;
  logic          ram_wr_en;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  entry_t        ram_wr_data;
  entry_t        rd_entry;
  logic          hit;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign not_full = (count_r < CW'(LOG_DEPTH));

  assign ram_wr_data.attribute = in_attribute;
  assign ram_wr_data.is_write  = in_is_write;
  assign ram_wr_data.txn_id    = in_txn_id;

  assign hit = (rd_entry.attribute == attr_r) && (rd_entry.txn_id != txn_r) &&
               (wr_r || rd_entry.is_write);

  rwcd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LOG_DEPTH),
    .AW    (AW)
  ) u_log_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_entry)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    txn_nxt       = txn_r;
    wr_nxt        = wr_r;
    attr_nxt      = attr_r;
    found_nxt     = found_r;
    ctxn_nxt      = ctxn_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_txn_nxt   = out_txn_r;
    out_ovf_nxt   = out_ovf_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = AW'(count_r - CW'(1));

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          txn_nxt   = in_txn_id;
          wr_nxt    = in_is_write;
          attr_nxt  = in_attribute;
          found_nxt = 1'b0;
          ctxn_nxt  = '0;
          ovf_nxt   = 1'b0;
          if (in_op == OP_CLEAR) begin
            count_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            ovf_nxt = !not_full;
            if (not_full) begin
              ram_wr_en = 1'b1;
              count_nxt = count_r + CW'(1);
            end
            if (count_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              // start with the newest stored entry
              ram_rd_en = 1'b1;
              idx_nxt   = AW'(count_r - CW'(1));
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        ram_rd_addr = idx_r - AW'(1);
        if (hit) begin
          found_nxt = 1'b1;
          ctxn_nxt  = rd_entry.txn_id;
          state_nxt = S_DONE;
        end else if (idx_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          ram_rd_en = 1'b1;
          idx_nxt   = idx_r - AW'(1);
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_txn_nxt   = ctxn_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    txn_r       <= txn_nxt;
    wr_r        <= wr_nxt;
    attr_r      <= attr_nxt;
    found_r     <= found_nxt;
    ctxn_r      <= ctxn_nxt;
    ovf_r       <= ovf_nxt;
    out_found_r <= out_found_nxt;
    out_txn_r   <= out_txn_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_conflict_found = out_found_r;
  assign out_conflict_txn   = out_txn_r;
  assign out_overflow       = out_ovf_r;

endmodule
